[rtl/core/spga_pkg.sv]
// Shared types and constants for the softened pair gravity accumulator.
// No dependencies.
`default_nettype none

package spga_pkg;

    // Register byte addresses on the configuration port (8-byte stride)
    localparam logic [3:0] ADDR_G_MASS  = 4'd0;
    localparam logic [3:0] ADDR_SOFT_SQ = 4'd8;

    localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;

    // Position difference of one classified pair, plus run marker
    typedef struct packed {
        logic signed [32:0] rx;
        logic signed [32:0] ry;
        logic signed [32:0] rz;
        logic               last;
    } pair_t;

    // Back end sequencer states
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQ   = 9'b000000010,
        ST_SQA  = 9'b000000100,
        ST_ROOT = 9'b000001000,
        ST_DIV  = 9'b000010000,
        ST_MUL  = 9'b000100000,
        ST_QUO0 = 9'b001000000,
        ST_QUO  = 9'b010000000,
        ST_ACC  = 9'b100000000
    } state_t;

    // Magnitude of a 33-bit signed difference (always below 2^32)
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] a;
        a = v[32] ? 33'(-v) : 33'(v);
        return a[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/spga_front.sv]
// Front end: accepts pair transfers, forms the position difference and
// queues classified pairs in a two-entry buffer. Depends on spga_pkg.
`default_nettype none

module spga_front
    import spga_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              q_valid,
    input  wire logic         q_ready,
    output pair_t             q_data
);

    pair_t      buf_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    pair_t      pair_in;
    logic       push, pop;

    // Difference source - target, 33-bit signed
    always_comb begin
        pair_in.rx   = 33'(signed'(s_tdata[127:96]))  - 33'(signed'(s_tdata[31:0]));
        pair_in.ry   = 33'(signed'(s_tdata[159:128])) - 33'(signed'(s_tdata[63:32]));
        pair_in.rz   = 33'(signed'(s_tdata[191:160])) - 33'(signed'(s_tdata[95:64]));
        pair_in.last = s_tlast;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = buf_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= pair_in;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

[rtl/core/spga_back.sv]
// Back end: iterative force engine (square sum, square root, two restoring
// dividers, one shared multiplier), saturating accumulator and result register.
// Depends on spga_pkg.
`default_nettype none

module spga_back
    import spga_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire pair_t         q_data,
    input  wire logic [31:0]   g_mass,
    input  wire logic [62:0]   softening_sq,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [151:0]       m_tdata
);

    state_t             state_reg;
    pair_t              pair_reg;
    logic [1:0]         comp_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        s_reg;
    logic [63:0]        v_reg;
    logic [63:0]        res_reg;
    logic [31:0]        q_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        u_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        r_reg;
    logic [46:0]        quo_reg;
    logic               big_reg;
    logic signed [47:0] sum_reg [3];
    logic               sat_reg;
    logic               out_valid_reg;
    logic [144:0]       out_reg;

    logic signed [32:0] rk;
    logic [31:0]        mk;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        bit_v, trial_root;
    logic [60:0]        dvd;
    logic [32:0]        trial_div;
    logic [64:0]        trial_quo, two_s;
    logic signed [48:0] term, acc;
    logic [47:0]        sum_sat;
    logic               sum_clip;
    logic               out_free, emit;

    // Component under work
    always_comb begin
        case (comp_reg)
            2'd0:    rk = pair_reg.rx;
            2'd1:    rk = pair_reg.ry;
            default: rk = pair_reg.rz;
        endcase
        mk = mag33(rk);
    end

    // Shared multiplier
    assign mul_a = (state_reg == ST_MUL) ? g_mass : mk;
    assign mul_b = (state_reg == ST_MUL) ? u_reg  : mk;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Square root step, divider steps
    assign bit_v      = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign trial_root = res_reg + bit_v;
    assign dvd        = {mk, 29'd0};
    assign trial_div  = {rem_reg, dvd[cnt_reg]};
    assign trial_quo  = {r_reg, 1'b0};
    assign two_s      = {s_reg, 1'b0};

    // Signed term and saturating add
    always_comb begin
        if (big_reg) begin
            term = rk[32] ? -49'sh8000_0000_0000 : 49'sh7FFF_FFFF_FFFF;
        end else begin
            term = rk[32] ? -signed'(49'(quo_reg)) : signed'(49'(quo_reg));
        end
        acc      = 49'(sum_reg[comp_reg]) + term;
        sum_clip = (acc[48] != acc[47]);
        sum_sat  = sum_clip ? (acc[48] ? ~POS_LIMIT : POS_LIMIT) : acc[47:0];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE);
    assign emit     = (state_reg == ST_ACC) && (comp_reg == 2'd2) && pair_reg.last
                      && out_free;

    // Divisor: root is registered on the first divide step of the item
    function automatic logic [31:0] q_sel();
        return (cnt_reg == 6'd60 && comp_reg == 2'd0) ? res_reg[31:0] : q_reg;
    endfunction

    // Sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            comp_reg  <= 2'd0;
            cnt_reg   <= 6'd0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
            sat_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        pair_reg  <= q_data;
                        comp_reg  <= 2'd0;
                        s_reg     <= 64'(softening_sq >> 2);
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQA;
                end
                ST_SQA: begin
                    if (comp_reg == 2'd2) begin
                        if ((s_reg + (prod_reg >> 2)) == 64'd0) begin
                            s_reg <= 64'd1;
                            v_reg <= 64'd1;
                        end else begin
                            s_reg <= s_reg + (prod_reg >> 2);
                            v_reg <= s_reg + (prod_reg >> 2);
                        end
                        res_reg   <= 64'd0;
                        cnt_reg   <= 6'd31;
                        state_reg <= ST_ROOT;
                    end else begin
                        s_reg     <= s_reg + (prod_reg >> 2);
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_ROOT: begin
                    if (v_reg >= trial_root) begin
                        v_reg   <= v_reg - trial_root;
                        res_reg <= (res_reg >> 1) + bit_v;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    if (cnt_reg == 6'd0) begin
                        state_reg <= ST_DIV;
                        comp_reg  <= 2'd0;
                        cnt_reg   <= 6'd60;
                        rem_reg   <= '0;
                        u_reg     <= '0;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == 6'd60) begin
                        q_reg <= res_reg[31:0];
                    end
                    if (trial_div >= 33'(q_sel())) begin
                        rem_reg <= 32'(trial_div - 33'(q_sel()));
                        u_reg   <= {u_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= trial_div[31:0];
                        u_reg   <= {u_reg[30:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0) begin
                        state_reg <= ST_MUL;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_QUO0;
                end
                ST_QUO0: begin
                    cnt_reg <= 6'd45;
                    if ({1'b0, prod_reg} >= two_s) begin
                        quo_reg   <= '0;
                        big_reg   <= 1'b1;
                        state_reg <= ST_ACC;
                    end else begin
                        big_reg   <= 1'b0;
                        state_reg <= ST_QUO;
                        if (prod_reg >= s_reg) begin
                            r_reg   <= prod_reg - s_reg;
                            quo_reg <= 47'd1;
                        end else begin
                            r_reg   <= prod_reg;
                            quo_reg <= '0;
                        end
                    end
                end
                ST_QUO: begin
                    if (trial_quo >= {1'b0, s_reg}) begin
                        r_reg   <= 64'(trial_quo - {1'b0, s_reg});
                        quo_reg <= {quo_reg[45:0], 1'b1};
                    end else begin
                        r_reg   <= trial_quo[63:0];
                        quo_reg <= {quo_reg[45:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0) begin
                        state_reg <= ST_ACC;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                ST_ACC: begin
                    if (comp_reg != 2'd2) begin
                        sum_reg[comp_reg] <= sum_sat;
                        if (big_reg || sum_clip) sat_reg <= 1'b1;
                        comp_reg  <= comp_reg + 2'd1;
                        cnt_reg   <= 6'd60;
                        rem_reg   <= '0;
                        u_reg     <= '0;
                        state_reg <= ST_DIV;
                    end else if (!pair_reg.last) begin
                        sum_reg[2] <= sum_sat;
                        if (big_reg || sum_clip) sat_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        sum_reg[0] <= '0;
                        sum_reg[1] <= '0;
                        sum_reg[2] <= '0;
                        sat_reg    <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= {sat_reg || big_reg || sum_clip, sum_sat,
                        sum_reg[1], sum_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

    // Checks
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (sum_reg[0] == 48'sd0 && sum_reg[1] == 48'sd0 && !sat_reg))
        else $error("sums not cleared after emit");
    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        comp_reg != 2'd3)
        else $error("component index out of range");
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg != 6'd60) |-> q_reg != 32'd0)
        else $error("zero divisor in direction divide");
    a_no_emit_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !emit)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[rtl/core/softened_pair_gravity_accumulator.sv]
// Top level: configuration registers, front end queue and back end engine.
// Depends on spga_pkg, spga_front, spga_back.
//
//  channel  dir  handshake               payload
//  s_       in   s_tvalid / s_tready     s_tdata (positions), s_tlast (last pair)
//  m_       out  m_tvalid / m_tready     m_tdata (accel x/y/z, overflow)
//  apb      in   psel / penable / pready paddr, pwdata, prdata
//
// The back end takes one pair at a time: it loads the pair, forms the square
// sum and the square root, and per component runs the divide steps, a
// multiply, the quotient steps and an accumulate; a saturating term skips
// the remaining quotient steps.
// A two-entry queue lets the front accept pairs while the back end works.
// Reset is synchronous, active low, and clears sums, flag and queue.
// A finished result waits in its register; only a new emit stalls on it.
`default_nettype none

module softened_pair_gravity_accumulator
    import spga_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // target_x, target_y, target_z, source_x/y/z
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // accel_x, accel_y, accel_z, overflow, zero pad
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [31:0] g_mass_reg;
    logic [62:0] soft_sq_reg;
    logic        q_valid, q_ready;
    pair_t       q_data;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_mass_reg  <= 32'd65536;
            soft_sq_reg <= '0;
        end else if (wr) begin
            if ({paddr[3], 3'b000} == ADDR_SOFT_SQ) begin
                soft_sq_reg <= pwdata[62:0];
            end else begin
                g_mass_reg <= pwdata[31:0];
            end
        end
    end

    assign prdata = ({paddr[3], 3'b000} == ADDR_G_MASS) ? {32'd0, g_mass_reg}
                                                        : {1'b0, soft_sq_reg};

    spga_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    spga_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .g_mass       (g_mass_reg),
        .softening_sq (soft_sq_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb_softened_pair_gravity_accumulator.sv]
// Self-checking testbench for softened_pair_gravity_accumulator: streams position pairs,
// predicts each summed acceleration in a scoreboard class and checks every result transfer.
// Depends on spga_pkg and the block's RTL.
`default_nettype none

module tb_softened_pair_gravity_accumulator
    import spga_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] tx, ty, tz, sx, sy, sz;
        logic        last;
    } pair_item_t;

    typedef struct {
        logic [47:0] ax, ay, az;
        logic        ovf;
    } accel_item_t;

    localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint NEG_MAX = -64'sh8000_0000_0000;

    // Keeps its own copy of registers and sums; queues the summed vectors
    class gravity_scoreboard;
        logic [31:0] g_mass;
        logic [62:0] soft_sq;
        longint      sum_x, sum_y, sum_z;
        bit          sat;
        accel_item_t pending_accel[$];
        int          errors;

        function new();
            g_mass  = 32'd65536;
            soft_sq = '0;
            sum_x = 0; sum_y = 0; sum_z = 0;
            sat = 0;
            errors = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // One component of g_mass * R / dist^3, clamped to the 48-bit range
        function longint axis_force(longint rk, logic [63:0] s, logic [63:0] q);
            logic [63:0]  m;
            logic [63:0]  u;
            logic [63:0]  p;
            logic [127:0] quo;
            logic [127:0] lim;
            m = (rk < 0) ? 64'(-rk) : 64'(rk);
            u = (m << 29) / q;
            p = 64'(64'(g_mass) * u);
            quo = {18'd0, p, 46'd0} / {64'd0, s};
            lim = (rk < 0) ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
            if (quo >= 128'h8000_0000_0000 || quo > lim) begin
                quo = lim;
                sat = 1;
            end
            return (rk < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function longint clamp_add(longint a, longint b);
            longint t;
            t = a + b;
            if (t > POS_MAX) begin
                t = POS_MAX;
                sat = 1;
            end else if (t < NEG_MAX) begin
                t = NEG_MAX;
                sat = 1;
            end
            return t;
        endfunction

        function void note_pair(pair_item_t it);
            longint      rx, ry, rz;
            logic [63:0] mx, my, mz, s, q;
            accel_item_t e;
            rx = longint'($signed(it.sx)) - longint'($signed(it.tx));
            ry = longint'($signed(it.sy)) - longint'($signed(it.ty));
            rz = longint'($signed(it.sz)) - longint'($signed(it.tz));
            mx = (rx < 0) ? 64'(-rx) : 64'(rx);
            my = (ry < 0) ? 64'(-ry) : 64'(ry);
            mz = (rz < 0) ? 64'(-rz) : 64'(rz);
            s = ((mx * mx) >> 2) + ((my * my) >> 2) + ((mz * mz) >> 2)
                + (64'(soft_sq) >> 2);
            if (s == 0) s = 1;
            q = int_sqrt(s);
            sum_x = clamp_add(sum_x, axis_force(rx, s, q));
            sum_y = clamp_add(sum_y, axis_force(ry, s, q));
            sum_z = clamp_add(sum_z, axis_force(rz, s, q));
            if (it.last) begin
                e.ax = sum_x[47:0];
                e.ay = sum_y[47:0];
                e.az = sum_z[47:0];
                e.ovf = sat;
                pending_accel.insert(pending_accel.size(), e);
                sum_x = 0; sum_y = 0; sum_z = 0;
                sat = 0;
            end
        endfunction

        function void check_result(logic [151:0] d);
            accel_item_t e;
            if (pending_accel.size() == 0) begin
                $error("result transfer with no expected acceleration: %h", d);
                errors++;
                return;
            end
            e = pending_accel.pop_front();
            if (d[47:0] !== e.ax) begin
                $error("accel_x expected %h got %h", e.ax, d[47:0]);
                errors++;
            end
            if (d[95:48] !== e.ay) begin
                $error("accel_y expected %h got %h", e.ay, d[95:48]);
                errors++;
            end
            if (d[143:96] !== e.az) begin
                $error("accel_z expected %h got %h", e.az, d[143:96]);
                errors++;
            end
            if (d[144] !== e.ovf) begin
                $error("overflow expected %b got %b", e.ovf, d[144]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // target_x, target_y, target_z, source_x, source_y, source_z
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;   // accel_x, accel_y, accel_z, overflow, zero pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    gravity_scoreboard sb;
    bit                no_idle;
    int                pair_count;

    softened_pair_gravity_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Mostly short gaps, a few long ones; none in a no-idle stretch
    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls
    always @(posedge aclk) begin
        if (!aresetn || no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 65) ? 1'b1 :
                        ($urandom_range(0, 9) == 0 ? 1'b0 : m_tready);
        end
    end

    // Result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_G_MASS) sb.g_mass = value[31:0];
        else if (addr == ADDR_SOFT_SQ) sb.soft_sq = value[62:0];
    endtask

    task automatic send_pair(input pair_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.sz, it.sy, it.sx, it.tz, it.ty, it.tx};
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(it);
        pair_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_accel.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    function pair_item_t make_pair(logic [31:0] tx, ty, tz, sx, sy, sz, logic last);
        pair_item_t it;
        it.tx = tx; it.ty = ty; it.tz = tz;
        it.sx = sx; it.sy = sy; it.sz = sz;
        it.last = last;
        return it;
    endfunction

    // Random pair: far, near, self or at the range ends
    function pair_item_t random_pair(logic last);
        pair_item_t it;
        int         k;
        int         sh;
        k = $urandom_range(0, 99);
        it.tx = $urandom; it.ty = $urandom; it.tz = $urandom;
        it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
        if (k < 40) begin
            sh = $urandom_range(0, 31);
            it.sx = it.tx + 32'($signed($urandom) >>> sh);
            it.sy = it.ty + 32'($signed($urandom) >>> sh);
            it.sz = it.tz + 32'($signed($urandom) >>> sh);
        end else if (k < 50) begin
            it.sx = it.tx; it.sy = it.ty; it.sz = it.tz;
        end else if (k < 60) begin
            it.tx = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            it.sx = ~it.tx;
            it.tz = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        it.last = last;
        return it;
    endfunction

    task automatic random_phase(input int n_items);
        int run;
        int i;
        i = 0;
        while (i < n_items) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 25) : $urandom_range(1, 8);
            no_idle = ($urandom_range(0, 5) == 0);
            for (int j = 0; j < run; j++) send_pair(random_pair(j == run - 1));
            i += run;
        end
        no_idle = 0;
        drain_results();
    endtask

    function logic [63:0] random_soft();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(2, 63);
    endfunction

    initial begin
        sb = new();
        no_idle = 0;
        pair_count = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: self pair, zero sum, extremes, unit offset, not-last runs
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1));
        send_pair(make_pair(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        send_pair(make_pair(32'h7FFF_FFFF, 0, 32'h8000_0000,
                            32'h8000_0000, 0, 32'h7FFF_FFFF, 1));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
        send_pair(make_pair(5, 5, 5, 5, 5, 6, 1));
        send_pair(make_pair(0, 0, 0, 32'h0000_0100, 32'h0000_0080, 32'hFFFF_FF00, 1));
        send_pair(make_pair(0, 0, 0, 32'h4000_0000, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 32'hC000_0000, 0, 0, 1));
        drain_results();

        // Zero mass, then maximum mass with a softening of 2^62
        reg_write(ADDR_G_MASS, 64'd0);
        reg_write(ADDR_SOFT_SQ, 64'd0);
        send_pair(make_pair(0, 0, 0, 3, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1));
        drain_results();
        reg_write(ADDR_G_MASS, 64'hFFFF_FFFF);
        reg_write(ADDR_SOFT_SQ, 64'h4000_0000_0000_0000);
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1));
        send_pair(make_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        drain_results();
        reg_write(ADDR_SOFT_SQ, 64'd0);
        send_pair(make_pair(0, 0, 0, 1, 1, 1, 0));
        send_pair(make_pair(0, 0, 0, 32'hFFFF_FFFF, 2, 0, 0));
        send_pair(make_pair(0, 0, 0, 2, 0, 32'hFFFF_FFFE, 1));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1));
        drain_results();

        // Random phases under several register settings
        random_phase(200);
        reg_write(ADDR_G_MASS, 64'd65536);
        reg_write(ADDR_SOFT_SQ, random_soft());
        random_phase(200);
        reg_write(ADDR_G_MASS, 64'($urandom));
        reg_write(ADDR_SOFT_SQ, 64'h4000_0000_0000_0000);
        random_phase(150);
        reg_write(ADDR_G_MASS, 64'($urandom_range(0, 65535)));
        reg_write(ADDR_SOFT_SQ, random_soft());
        random_phase(150);
        reg_write(ADDR_G_MASS, 64'hFFFF_FFFF);
        reg_write(ADDR_SOFT_SQ, 64'd0);
        random_phase(180);

        if (sb.errors == 0 && sb.pending_accel.size() == 0) begin
            $display("tb_softened_pair_gravity_accumulator OK");
        end else begin
            $display("tb_softened_pair_gravity_accumulator NOT OK");
        end
        $finish;
    end

    // Run limit
    initial begin
        #60ms;
        $display("tb_softened_pair_gravity_accumulator NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
